>>> src/wildcard_byte_pattern_scanner_assert.svh
// Assertion macros used by the scanner's checker.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Clocked assertion, ignored while reset is high.
`define WBPS_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define WBPS_ASSERT_RST(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> src/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

  // Default window depth and captured pointer size
  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int POINTER_BYTES_DEF     = 8;

  // Pattern bytes held by the configuration registers
  localparam int CONFIG_PATTERN_BYTES = 16;

  // Configuration register map
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW   = 3'd0,
    CFG_PATTERN_HIGH  = 3'd1,
    CFG_WILDCARD_MASK = 3'd2,
    CFG_PATTERN_LEN   = 3'd3,
    CFG_CAPTURE_POS   = 3'd4,
    CFG_REPORT_START  = 3'd5,
    CFG_RESULT_OFFSET = 3'd6
  } cfg_index_t;

  // Reset values of the configuration registers
  localparam logic [4:0] PATTERN_LEN_RST = 5'd1;
  localparam logic [4:0] CAPTURE_POS_RST = 5'd16;

endpackage

`default_nettype wire

>>> src/wildcard_byte_pattern_scanner.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------
// in       | in_valid/in_ready   | data_byte, byte_address, new_scan
// out      | out_valid/out_ready | result_value, match_start
// cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte per cycle while in_ready is high; a matching byte is registered in stage one, then in the output register.
// Stage one holds the shifted window; the compare runs into the output register.
// in_ready drops only while a held result is stalled and stage one is full.
// Synchronous reset clears the fill count and stage valids, and sets the config registers to their reset values.
// cfg_ready is always high.
`default_nettype none

module wildcard_byte_pattern_scanner
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int POINTER_BYTES     = POINTER_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input words
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           data_byte,
  input  wire logic [63:0]          byte_address,
  input  wire logic                 new_scan,
  // result words
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [63:0]               result_value,
  output logic [63:0]               match_start,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  localparam int LIM = (MAX_PATTERN_BYTES < CONFIG_PATTERN_BYTES) ?
                       MAX_PATTERN_BYTES : CONFIG_PATTERN_BYTES;
  localparam int IW  = $clog2(MAX_PATTERN_BYTES);
  localparam int FW  = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int CW  = ((FW > 5) ? FW : 5) + 1;
  localparam int PW  = 8 * POINTER_BYTES;

  // Configuration registers
  logic [127:0] pattern;
  logic [15:0]  wildcard_mask;
  logic [4:0]   pattern_length;
  logic [4:0]   capture_position;
  logic         report_from_start;
  logic [15:0]  result_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern           <= '0;
      wildcard_mask     <= '0;
      pattern_length    <= PATTERN_LEN_RST;
      capture_position  <= CAPTURE_POS_RST;
      report_from_start <= 1'b1;
      result_offset     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PATTERN_LOW:   pattern[63:0]     <= cfg_data;
        CFG_PATTERN_HIGH:  pattern[127:64]   <= cfg_data;
        CFG_WILDCARD_MASK: wildcard_mask     <= cfg_data[15:0];
        CFG_PATTERN_LEN:   pattern_length    <= cfg_data[4:0];
        CFG_CAPTURE_POS:   capture_position  <= cfg_data[4:0];
        CFG_REPORT_START:  report_from_start <= cfg_data[0];
        CFG_RESULT_OFFSET: result_offset     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, saturated to the window
  logic [4:0] len_eff;
  logic [4:0] len_m1;
  assign len_eff = (pattern_length > 5'(LIM)) ? 5'(LIM) : pattern_length;
  assign len_m1  = len_eff - 5'd1;

  // Handshake: stage one moves on whenever the output register is free
  logic s1_valid;
  logic out_free;
  logic in_take;
  assign out_free = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_free;
  assign in_take  = in_valid && in_ready;

  // Stage one: byte window, fill count and precomputed addresses
  logic [7:0]    win [MAX_PATTERN_BYTES];
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_base;
  logic [FW-1:0] fill_next;
  logic [63:0]   s1_start;
  logic [63:0]   s1_start_val;
  logic [63:0]   s1_end_val;
  logic [17:0]   adj_start;
  logic [17:0]   adj_end;

  assign fill_base = new_scan ? '0 : fill;
  assign fill_next = (fill_base < FW'(MAX_PATTERN_BYTES)) ? fill_base + FW'(1) : fill_base;

  // offset - (len - 1) and offset + 1, as small signed values
  assign adj_start = 18'(signed'(result_offset)) - {13'd0, len_m1};
  assign adj_end   = 18'(signed'(result_offset)) + 18'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fill     <= '0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
        fill     <= fill_next;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      win[0] <= data_byte;
      for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
        win[i] <= win[i-1];
      end
      s1_start     <= byte_address - {59'd0, len_m1};
      s1_start_val <= byte_address + 64'(signed'(adj_start));
      s1_end_val   <= byte_address + 64'(signed'(adj_end));
    end
  end

  // Compare: pattern byte j against the window byte len-1-j
  logic            lane_ok [LIM];
  logic [4:0]      lane_idx [LIM];
  logic            all_ok;
  logic            match;

  always_comb begin
    for (int j = 0; j < LIM; j++) begin
      lane_idx[j] = len_m1 - 5'(j);
      lane_ok[j]  = (5'(j) >= len_eff) || wildcard_mask[j] ||
                    (win[lane_idx[j][IW-1:0]] == pattern[8*j +: 8]);
    end
  end

  always_comb begin
    all_ok = 1'b1;
    for (int j = 0; j < LIM; j++) begin
      all_ok = all_ok && lane_ok[j];
    end
  end

  assign match = (len_eff != 5'd0) && (CW'(fill) >= CW'(len_eff)) && all_ok;

  // Pointer capture, little-endian, bytes past the pattern read as zero
  logic          cap_active;
  logic [5:0]    cap_pos [POINTER_BYTES];
  logic [4:0]    cap_idx [POINTER_BYTES];
  logic [PW-1:0] pointer;

  assign cap_active = capture_position < len_eff;

  always_comb begin
    for (int b = 0; b < POINTER_BYTES; b++) begin
      cap_pos[b] = {1'b0, capture_position} + 6'(b);
      cap_idx[b] = 5'({1'b0, len_eff} - 6'd1 - cap_pos[b]);
      if (cap_pos[b] < {1'b0, len_eff}) begin
        pointer[8*b +: 8] = win[cap_idx[b][IW-1:0]];
      end else begin
        pointer[8*b +: 8] = 8'd0;
      end
    end
  end

  // Result value selection
  logic [63:0] value_next;
  always_comb begin
    if (cap_active) begin
      value_next = 64'(pointer) + 64'(signed'(result_offset));
    end else if (report_from_start) begin
      value_next = s1_start_val;
    end else begin
      value_next = s1_end_val;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && match;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid && match) begin
      result_value <= value_next;
      match_start  <= s1_start;
    end
  end

endmodule

`default_nettype wire

>>> src/wbps_checker.sv
`default_nettype none
`include "wildcard_byte_pattern_scanner_assert.svh"

module wbps_checker
  import wbps_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] result_value,
  input wire logic [63:0] match_start
);

  // No result word survives a reset
  `WBPS_ASSERT_RST(a_reset_clears_out, clk, $past(rst) |-> !out_valid, "out_valid after reset")

  // A stalled result word holds its payload
  property p_out_hold;
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(match_start);
  endproperty

  `WBPS_ASSERT(a_out_hold, clk, rst, p_out_hold, "result word changed while stalled")

  // Input side only stalls behind a stalled output
  property p_in_ready_free;
    (!out_valid || out_ready) |-> in_ready;
  endproperty

  `WBPS_ASSERT(a_in_ready_free, clk, rst, p_in_ready_free, "in_ready low with free output")

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);

`default_nettype wire

>>> bench/tb_wildcard_byte_pattern_scanner.sv
`default_nettype none

module tb_wildcard_byte_pattern_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  localparam int WIN_BYTES     = MAX_PATTERN_BYTES_DEF;
  localparam int PTR_BYTES     = POINTER_BYTES_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int CYCLE_LIMIT   = 400000;

  // one expected hit: reported value and window start address
  typedef struct packed {
    logic [63:0] value;
    logic [63:0] start;
  } scan_hit_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           data_byte = '0;
  logic [63:0]          byte_address = '0;
  logic                 new_scan = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [63:0]          result_value;
  logic [63:0]          match_start;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PATTERN_LOW;
  logic [63:0]          cfg_data = '0;

  wildcard_byte_pattern_scanner u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .byte_address (byte_address),
    .new_scan     (new_scan),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .match_start  (match_start),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // scanner copy: registers, byte window and fill count
  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [15:0] wild_mask;
  logic [4:0]  pat_len;
  logic [4:0]  cap_pos;
  logic        from_start;
  logic [15:0] res_offset;
  logic [7:0]  window [WIN_BYTES];
  int          window_fill;

  scan_hit_t   hits_due [$];
  int          errors = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;
  logic [63:0] scan_addr = '0;

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void reset_scanner_copy();
    pat_lo      = '0;
    pat_hi      = '0;
    wild_mask   = '0;
    pat_len     = PATTERN_LEN_RST;
    cap_pos     = CAPTURE_POS_RST;
    from_start  = 1'b1;
    res_offset  = '0;
    window_fill = 0;
    for (int i = 0; i < WIN_BYTES; i++) window[i] = '0;
  endfunction

  function automatic void record_cfg_write(cfg_index_t idx, logic [63:0] val);
    case (idx)
      CFG_PATTERN_LOW:   pat_lo     = val;
      CFG_PATTERN_HIGH:  pat_hi     = val;
      CFG_WILDCARD_MASK: wild_mask  = val[15:0];
      CFG_PATTERN_LEN:   pat_len    = val[4:0];
      CFG_CAPTURE_POS:   cap_pos    = val[4:0];
      CFG_REPORT_START:  from_start = val[0];
      CFG_RESULT_OFFSET: res_offset = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] pattern_at(int k);
    return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
  endfunction

  function automatic int eff_length();
    return (pat_len > WIN_BYTES) ? WIN_BYTES : int'(pat_len);
  endfunction

  // shift one byte in and queue the hit it produces, if any
  function automatic void scan_predict(logic [7:0] data, logic [63:0] addr, logic fresh);
    int          len;
    logic [63:0] start;
    logic [63:0] val;
    scan_hit_t   hit;
    if (fresh) window_fill = 0;
    for (int i = WIN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = data;
    if (window_fill < WIN_BYTES) window_fill++;
    len = eff_length();
    if (len == 0 || window_fill < len) return;
    for (int j = 0; j < len; j++)
      if (!wild_mask[j] && window[len-1-j] != pattern_at(j)) return;
    start = addr - 64'(len - 1);
    if (int'(cap_pos) < len) begin
      // little-endian pointer; bytes past the pattern read as zero
      val = '0;
      for (int b = 0; b < PTR_BYTES; b++)
        if (int'(cap_pos) + b < len) val[8*b +: 8] = window[len-1-int'(cap_pos)-b];
    end else if (from_start) begin
      val = start;
    end else begin
      val = start + 64'(len);
    end
    hit.value = val + {{48{res_offset[15]}}, res_offset};
    hit.start = start;
    hits_due = {hits_due, hit};
  endfunction

  // result side: check each accepted word, then pick next ready
  always @(posedge clk) begin : result_check
    scan_hit_t due;
    if (!rst && out_valid && out_ready) begin
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected word: value %h start %h", $time, result_value,
                 match_start);
        errors++;
      end else begin
        due = hits_due.pop_front();
        if (result_value !== due.value) begin
          $display("%0t: result_value expected %h actual %h", $time, due.value,
                   result_value);
          errors++;
        end
        if (match_start !== due.start) begin
          $display("%0t: match_start expected %h actual %h", $time, due.start,
                   match_start);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // send one input word; valid stays up for a following word
  task automatic send_byte(logic [7:0] data, logic [63:0] addr, logic fresh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= data;
    byte_address <= addr;
    new_scan     <= fresh;
    do @(posedge clk); while (!in_ready);
    scan_predict(data, addr, fresh);
    items_sent++;
  endtask

  // next byte of the running scan; occasional stray new scan
  task automatic stream_byte(logic [7:0] data, logic fresh);
    send_byte(data, scan_addr, fresh || ($urandom_range(49) == 0));
    scan_addr++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (hits_due.size() != 0);
  endtask

  // drained and nothing left in the pipe
  task automatic settle_block();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_index_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    record_cfg_write(idx, val);
  endtask

  task automatic load_setup(logic [63:0] lo, logic [63:0] hi, logic [63:0] mask,
                            logic [63:0] len, logic [63:0] cap, logic [63:0] from_st,
                            logic [63:0] offset);
    cfg_write(CFG_PATTERN_LOW, lo);
    cfg_write(CFG_PATTERN_HIGH, hi);
    cfg_write(CFG_WILDCARD_MASK, mask);
    cfg_write(CFG_PATTERN_LEN, len);
    cfg_write(CFG_CAPTURE_POS, cap);
    cfg_write(CFG_REPORT_START, from_st);
    cfg_write(CFG_RESULT_OFFSET, offset);
    cfg_valid <= 1'b0;
  endtask

  // random register set; upper bits of narrow fields carry junk
  task automatic random_setup();
    int          pick;
    int          eff;
    logic [63:0] mask_w;
    logic [63:0] len_w;
    logic [63:0] cap_w;
    logic [63:0] from_w;
    logic [63:0] off_w;
    mask_w = {$urandom, $urandom};
    len_w  = {$urandom, $urandom};
    cap_w  = {$urandom, $urandom};
    from_w = {$urandom, $urandom};
    off_w  = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 5)       len_w[4:0] = 5'd0;
    else if (pick < 12) len_w[4:0] = 5'($urandom_range(31, 17));
    else if (pick < 55) len_w[4:0] = 5'($urandom_range(4, 1));
    else                len_w[4:0] = 5'($urandom_range(16, 5));
    eff = (len_w[4:0] > WIN_BYTES) ? WIN_BYTES : int'(len_w[4:0]);
    pick = $urandom_range(99);
    if (pick < 35)              cap_w[4:0] = 5'd16;
    else if (pick < 50 || !eff) cap_w[4:0] = 5'($urandom_range(31, 0));
    else                        cap_w[4:0] = 5'($urandom_range(eff - 1, 0));
    pick = $urandom_range(99);
    if (pick < 30)      mask_w[15:0] = '0;
    else if (pick < 75) mask_w[15:0] = 16'($urandom & $urandom);
    else if (pick < 92) mask_w[15:0] = 16'($urandom);
    else                mask_w[15:0] = '1;
    pick = $urandom_range(99);
    if (pick < 25)      off_w[15:0] = '0;
    else if (pick < 33) off_w[15:0] = 16'h8000;
    else if (pick < 41) off_w[15:0] = 16'h7FFF;
    else if (pick < 49) off_w[15:0] = 16'hFFFF;
    else                off_w[15:0] = 16'($urandom);
    load_setup({$urandom, $urandom}, {$urandom, $urandom}, mask_w, len_w, cap_w,
               from_w, off_w);
  endtask

  function automatic logic [7:0] wanted_byte(int j);
    return wild_mask[j] ? 8'($urandom) : pattern_at(j);
  endfunction

  // one stretch of scan traffic: occurrences, spoiled ones, noise, jumps
  task automatic scan_burst();
    int         eff;
    int         pick;
    int         cut;
    logic [7:0] b;
    eff  = eff_length();
    pick = $urandom_range(99);
    if (eff > 0 && pick < 60) begin
      for (int j = 0; j < eff; j++) stream_byte(wanted_byte(j), 1'b0);
    end else if (eff > 0 && pick < 75) begin
      // one byte flipped, or a new scan partway through
      cut = $urandom_range(eff - 1, 0);
      for (int j = 0; j < eff; j++) begin
        b = wanted_byte(j);
        if (j == cut && pick < 68) b = ~b;
        stream_byte(b, j == cut && pick >= 68 && cut > 0);
      end
    end else if (pick < 90) begin
      repeat ($urandom_range(6, 1)) stream_byte(8'($urandom), 1'b0);
    end else begin
      case ($urandom_range(2))
        0:       scan_addr = {$urandom, $urandom};
        1:       scan_addr = 64'($urandom_range(40));
        default: scan_addr = '1 - 64'($urandom_range(40));
      endcase
      stream_byte(8'($urandom), 1'($urandom_range(1)));
    end
  endtask

  // exact bytes, a wildcard slot, a new scan that breaks a match, address wrap
  task automatic test_wildcard_match();
    settle_block();
    load_setup(64'h0000_0000_EF00_ADDE, '1, 64'h0004, 64'd4, 64'd16, 64'd1, 64'd0);
    send_byte(8'hDE, 64'h1000, 1'b1);
    send_byte(8'hAD, 64'h1001, 1'b0);
    send_byte(8'h77, 64'h1002, 1'b0);
    send_byte(8'hEF, 64'h1003, 1'b0);
    send_byte(8'hDE, 64'h2000, 1'b0);
    send_byte(8'hAD, 64'h2001, 1'b0);
    send_byte(8'h77, 64'h2002, 1'b1);
    send_byte(8'hEF, 64'h2003, 1'b0);
    send_byte(8'hDE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    send_byte(8'hAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_byte(8'h00, 64'h0, 1'b0);
    send_byte(8'hEF, 64'h1, 1'b0);
  endtask

  // end address with most negative offset, then capture running past the pattern
  task automatic test_result_modes();
    settle_block();
    load_setup(64'h0000_0000_EF00_ADDE, '1, 64'h0004, 64'd4, 64'd16, 64'd0, 64'h8000);
    send_byte(8'hDE, 64'h10, 1'b0);
    send_byte(8'hAD, 64'h11, 1'b0);
    send_byte(8'hFF, 64'h12, 1'b0);
    send_byte(8'hEF, 64'h13, 1'b0);
    settle_block();
    load_setup(64'h0000_0000_EF00_ADDE, '1, 64'h0004, 64'd4, 64'd2, 64'd1, 64'h7FFF);
    send_byte(8'hDE, 64'h20, 1'b0);
    send_byte(8'hAD, 64'h21, 1'b0);
    send_byte(8'hFF, 64'h22, 1'b0);
    send_byte(8'hEF, 64'h23, 1'b0);
  endtask

  // zero length never matches; oversize length clamps to the full window
  task automatic test_length_limits();
    settle_block();
    load_setup(64'h0, 64'h0, 64'h0, 64'd0, 64'd16, 64'd1, 64'd0);
    send_byte(8'h00, 64'h30, 1'b0);
    send_byte(8'hFF, 64'h31, 1'b0);
    settle_block();
    load_setup(64'h0, 64'h0, 64'hFFFF, 64'd31, 64'd16, 64'd1, 64'd0);
    send_byte(8'h00, 64'h32, 1'b0);
    send_byte(8'hFF, 64'h33, 1'b0);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int n_items);
    int target;
    send_idle_pct = idle_pct;
    rx_stall_pct  = stall_pct;
    target        = items_sent + n_items;
    scan_addr     = {$urandom, $urandom};
    while (items_sent < target) begin
      settle_block();
      random_setup();
      repeat ($urandom_range(14, 4)) begin
        scan_burst();
        if ($urandom_range(19) == 0) wait_drained();
      end
    end
  endtask

  // long receiver hold while every byte matches: input must back up
  task automatic test_output_backpressure();
    settle_block();
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    load_setup({$urandom, $urandom}, {$urandom, $urandom}, 64'h1, 64'd1, 64'd16,
               64'd1, 64'hFFFF);
    hold_left = 200;
    repeat (40) stream_byte(8'($urandom), 1'b0);
    wait_drained();
  endtask

  initial begin
    reset_scanner_copy();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_wildcard_match();
    test_result_modes();
    test_length_limits();
    test_random_phase(0, 0, 380);
    test_random_phase(52, 0, 380);
    test_random_phase(0, 52, 380);
    test_random_phase(16, 16, 380);
    test_output_backpressure();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> wildcard_byte_pattern_scanner.f
+incdir+src
src/wbps_pkg.sv
src/wildcard_byte_pattern_scanner.sv
src/wbps_checker.sv
bench/tb_wildcard_byte_pattern_scanner.sv
